// ===== design/dasr_pkg.sv =====
// ----------------------------------------------------------------------------
// dasr_pkg
// Types, constants and the easing weight function of the speed randomizer.
// ----------------------------------------------------------------------------
package dasr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SPD_W     = FRAC_BITS + 1;
  localparam int ANG_W     = FRAC_BITS + 9;
  localparam int CFG_IDX_W = 3;

  localparam int TRANSITION_TICKS_DEF = 125;
  localparam int RESCALE_LIMIT_DEF    = 16;

  localparam logic [2:0] REG_MIN_SPEED    = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
  localparam logic [2:0] REG_MIN_RATIO    = 3'd2;
  localparam logic [2:0] REG_MAX_RATIO    = 3'd3;
  localparam logic [2:0] REG_FIXED_RATIO  = 3'd4;
  localparam logic [2:0] REG_RATIO_MODE   = 3'd5;
  localparam logic [2:0] REG_STABLE_TICKS = 3'd6;

  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RAND  = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [63:0] Q30    = 64'd1 << 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [SPD_W-1:0] K_0P8  = SPD_W'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [SPD_W-1:0] K_1P2  = SPD_W'(((64'd12 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [SPD_W-1:0] HALF_F = SPD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [SPD_W-1:0] OUTER_RST = HALF_F;
  localparam logic [SPD_W-1:0] INNER_RST = K_0P8;
  localparam logic [SPD_W-1:0] RATIO_RST =
    SPD_W'(((64'd1618 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [ANG_W:0] DEG360 = (ANG_W+1)'(64'd360 << FRAC_BITS);

  localparam logic [63:0] CYC_RND = 64'd1 << (29 - FRAC_BITS);
  localparam logic [SPD_W-1:0] CYC_R0 = SPD_W'((64'd1518500250 + CYC_RND) >> (30 - FRAC_BITS));
  localparam logic [SPD_W-1:0] CYC_R1 = SPD_W'((64'd1737350766 + CYC_RND) >> (30 - FRAC_BITS));
  localparam logic [SPD_W-1:0] CYC_R2 = SPD_W'((64'd1610612736 + CYC_RND) >> (30 - FRAC_BITS));
  localparam logic [SPD_W-1:0] CYC_R3 = SPD_W'((64'd1859720839 + CYC_RND) >> (30 - FRAC_BITS));

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] speed_draw;
    logic [15:0] ratio_draw;
  } dasr_in_t;

  typedef struct packed {
    logic [ANG_W-1:0] outer_angle;
    logic [ANG_W-1:0] inner_angle;
    logic [SPD_W-1:0] outer_speed;
    logic [SPD_W-1:0] inner_speed;
    logic [SPD_W-1:0] ratio_now;
    logic             in_transition;
    logic             rescale_capped;
  } dasr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAW_R, ST_DRAW_O, ST_INNER, ST_CHECK, ST_SCALE,
    ST_EASE_O, ST_EASE_I, ST_ANGLE, ST_OUT
  } dasr_state_t;

  function automatic logic [SPD_W-1:0] ease_weight_q(input logic [63:0] x,
                                                     input logic upper);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = Q30 - x2 / 64'd72;
    t  = Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    if (s > Q30) s = Q30;
    s = upper ? Q30 + s : Q30 - s;
    return SPD_W'((s + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
  endfunction

endpackage

// ===== design/dual_axis_speed_randomizer_unit.sv =====
// ----------------------------------------------------------------------------
// dual_axis_speed_randomizer_unit
// Two-axis speed setpoint generator with shared multiplier and sequencer.
// ----------------------------------------------------------------------------
// channel  direction  ports                         word
// in       input      in_valid in_stall in_data     dasr_in_t
// out      output     out_valid out_stall out_data  dasr_out_t
// cfg      input      cfg_we cfg_index cfg_data     17-bit register write
//
// A status word goes straight to output, a plain tick via the angle step and an
// easing tick via both easing steps and angle (its last tick skips the easing).
// A target pick runs draw, inner, check, then angle on a tick only, with a ratio
// draw first in random ratio mode and up to RESCALE_LIMIT scale-inner-check passes.
// Reset is synchronous; no clearing pass. in_stall is high while a word is
// in progress; a finished word waits in the output register and holds the
// next result until it is taken.
// ----------------------------------------------------------------------------
module dual_axis_speed_randomizer_unit #(
  parameter int TRANSITION_TICKS = dasr_pkg::TRANSITION_TICKS_DEF,
  parameter int RESCALE_LIMIT    = dasr_pkg::RESCALE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dasr_pkg::dasr_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dasr_pkg::dasr_out_t       out_data,
  input  logic                      cfg_we,
  input  logic [dasr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dasr_pkg::SPD_W-1:0] cfg_data
);
  import dasr_pkg::*;

  localparam int OW     = 18 + (RESCALE_LIMIT * 27 + 99) / 100;
  localparam int IW     = OW + 1;
  localparam int PW     = OW + SPD_W;
  localparam int PASS_W = $clog2(RESCALE_LIMIT + 1);
  localparam logic [7:0] TT8 = 8'(TRANSITION_TICKS);

  logic [SPD_W-1:0] wt_tab [256];

  for (genvar k = 0; k < 256; k++) begin : g_wt
    localparam logic        UP  = (2 * k) > TRANSITION_TICKS;
    localparam logic [63:0] NUM = UP ? 64'(2 * k - TRANSITION_TICKS)
                                     : 64'(TRANSITION_TICKS - 2 * k);
    localparam logic [63:0] XV  = PI_Q30 * NUM / 64'(2 * TRANSITION_TICKS);
    assign wt_tab[k] = ease_weight_q(XV, UP);
  end

  dasr_state_t state_r, state_nxt;

  logic [SPD_W-1:0] min_spd_r, max_spd_r, min_rat_r, max_rat_r, fix_rat_r;
  logic [1:0]       mode_r;
  logic [9:0]       stable_r;

  logic [ANG_W-1:0] oang_r, oang_nxt, iang_r, iang_nxt;
  logic [SPD_W-1:0] ospd_r, ospd_nxt, ispd_r, ispd_nxt;
  logic [SPD_W-1:0] otgt_r, otgt_nxt, itgt_r, itgt_nxt;
  logic [SPD_W-1:0] ratio_r, ratio_nxt;
  logic             easing_r, easing_nxt, capped_r, capped_nxt;
  logic [9:0]       sc_r, sc_nxt;
  logic [7:0]       ec_r, ec_nxt;
  logic [1:0]       cidx_t_r, cidx_t_nxt, cidx_c_r, cidx_c_nxt;
  logic             cmd_r, cmd_nxt;
  logic [15:0]      sdraw_r, sdraw_nxt, rdraw_r, rdraw_nxt;
  logic [OW-1:0]    outer_r, outer_nxt;
  logic [IW-1:0]    inner_r, inner_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic             out_valid_r, out_valid_nxt;
  dasr_out_t        out_r, out_nxt;

  logic             accept;
  logic [OW-1:0]    mul_a;
  logic [SPD_W-1:0] mul_b;
  logic [PW-1:0]    prod, prod_rnd;
  logic [SPD_W-1:0] s_lo, s_hi, r_lo, r_hi;
  logic [SPD_W-1:0] o_diff, i_diff, cyc_ratio;
  logic             o_up, i_up;
  logic [9:0]       sc_inc;
  logic [7:0]       ec_inc;
  logic             hi_chk, lo_chk;
  logic [ANG_W:0]   oang_sum, iang_sum;
  logic [SPD_W-1:0] otgt_sat, itgt_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign s_lo = (min_spd_r < max_spd_r) ? min_spd_r : max_spd_r;
  assign s_hi = (min_spd_r < max_spd_r) ? max_spd_r : min_spd_r;
  assign r_lo = (min_rat_r < max_rat_r) ? min_rat_r : max_rat_r;
  assign r_hi = (min_rat_r < max_rat_r) ? max_rat_r : min_rat_r;
  assign o_up = otgt_r >= ospd_r;
  assign i_up = itgt_r >= ispd_r;
  assign o_diff = o_up ? otgt_r - ospd_r : ospd_r - otgt_r;
  assign i_diff = i_up ? itgt_r - ispd_r : ispd_r - itgt_r;
  assign sc_inc = sc_r + 10'd1;
  assign ec_inc = ec_r + 8'd1;

  always_comb begin
    case (in_data.kind == KIND_TICK ? cidx_t_r : cidx_c_r)
      2'd0:    cyc_ratio = CYC_R0;
      2'd1:    cyc_ratio = CYC_R1;
      2'd2:    cyc_ratio = CYC_R2;
      default: cyc_ratio = CYC_R3;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DRAW_R: begin mul_a = OW'(r_hi - r_lo); mul_b = SPD_W'(rdraw_r); end
      ST_DRAW_O: begin mul_a = OW'(s_hi - s_lo); mul_b = SPD_W'(sdraw_r); end
      ST_INNER:  begin mul_a = outer_r; mul_b = ratio_r; end
      ST_SCALE:  begin mul_a = outer_r; mul_b = hi_chk ? K_0P8 : K_1P2; end
      ST_EASE_O: begin mul_a = OW'(o_diff); mul_b = wt_tab[ec_r]; end
      ST_EASE_I: begin mul_a = OW'(i_diff); mul_b = wt_tab[ec_r]; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign prod_rnd = (prod + PW'(HALF_F)) >> FRAC_BITS;

  assign hi_chk = (inner_r > IW'(max_spd_r)) || (!cmd_r && outer_r > OW'(max_spd_r));
  assign lo_chk = (inner_r < IW'(min_spd_r)) || (!cmd_r && outer_r < OW'(min_spd_r));
  assign otgt_sat = (outer_r > OW'({SPD_W{1'b1}})) ? {SPD_W{1'b1}} : outer_r[SPD_W-1:0];
  assign itgt_sat = (inner_r > IW'({SPD_W{1'b1}})) ? {SPD_W{1'b1}} : inner_r[SPD_W-1:0];

  assign oang_sum = {1'b0, oang_r} + (ANG_W+1)'(ospd_r);
  assign iang_sum = {1'b0, iang_r} + (ANG_W+1)'(ispd_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_TICK) begin
            if (easing_r) begin
              state_nxt = (ec_inc >= TT8) ? ST_ANGLE : ST_EASE_O;
            end else if (sc_inc >= stable_r) begin
              state_nxt = (mode_r == MODE_RANDOM) ? ST_DRAW_R : ST_DRAW_O;
            end else begin
              state_nxt = ST_ANGLE;
            end
          end else if (in_data.kind == KIND_RAND || in_data.kind == KIND_RESET) begin
            state_nxt = (mode_r == MODE_RANDOM) ? ST_DRAW_R : ST_DRAW_O;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DRAW_R: state_nxt = ST_DRAW_O;
      ST_DRAW_O: state_nxt = ST_INNER;
      ST_INNER:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if ((!hi_chk && !lo_chk) || pass_r >= PASS_W'(RESCALE_LIMIT)) begin
          state_nxt = cmd_r ? ST_OUT : ST_ANGLE;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:  state_nxt = ST_INNER;
      ST_EASE_O: state_nxt = ST_EASE_I;
      ST_EASE_I: state_nxt = ST_ANGLE;
      ST_ANGLE:  state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    oang_nxt = oang_r;   iang_nxt = iang_r;
    ospd_nxt = ospd_r;   ispd_nxt = ispd_r;
    otgt_nxt = otgt_r;   itgt_nxt = itgt_r;
    ratio_nxt = ratio_r; easing_nxt = easing_r; capped_nxt = capped_r;
    sc_nxt = sc_r;       ec_nxt = ec_r;
    cidx_t_nxt = cidx_t_r; cidx_c_nxt = cidx_c_r;
    cmd_nxt = cmd_r;     sdraw_nxt = sdraw_r; rdraw_nxt = rdraw_r;
    outer_nxt = outer_r; inner_nxt = inner_r; pass_nxt = pass_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sdraw_nxt = in_data.speed_draw;
          rdraw_nxt = in_data.ratio_draw;
          cmd_nxt   = (in_data.kind != KIND_TICK);
          pass_nxt  = '0;
          if (in_data.kind == KIND_TICK) begin
            if (easing_r) begin
              ec_nxt = ec_inc;
              if (ec_inc >= TT8) begin
                ospd_nxt = otgt_r;
                ispd_nxt = itgt_r;
                easing_nxt = 1'b0;
                sc_nxt = '0;
              end
            end else if (sc_inc >= stable_r) begin
              easing_nxt = 1'b1;
              sc_nxt = '0;
              ec_nxt = '0;
              capped_nxt = 1'b0;
              if (mode_r == MODE_FIXED) begin
                ratio_nxt = fix_rat_r;
              end else if (mode_r != MODE_RANDOM) begin
                ratio_nxt = cyc_ratio;
                cidx_t_nxt = cidx_t_r + 2'd1;
              end
            end else begin
              sc_nxt = sc_inc;
            end
          end else if (in_data.kind == KIND_RAND || in_data.kind == KIND_RESET) begin
            if (in_data.kind == KIND_RESET) begin
              oang_nxt = '0;
              iang_nxt = '0;
            end
            easing_nxt = 1'b0;
            sc_nxt = '0;
            ec_nxt = '0;
            capped_nxt = 1'b0;
            if (mode_r == MODE_FIXED) begin
              ratio_nxt = fix_rat_r;
            end else if (mode_r != MODE_RANDOM) begin
              ratio_nxt = cyc_ratio;
              cidx_c_nxt = cidx_c_r + 2'd1;
            end
          end
        end
      end
      ST_DRAW_R: ratio_nxt = r_lo + SPD_W'(prod >> 16);
      ST_DRAW_O: outer_nxt = OW'(s_lo) + OW'(prod >> 16);
      ST_INNER:  inner_nxt = IW'(prod_rnd);
      ST_CHECK: begin
        if ((!hi_chk && !lo_chk) || pass_r >= PASS_W'(RESCALE_LIMIT)) begin
          capped_nxt = hi_chk || lo_chk;
          otgt_nxt = otgt_sat;
          itgt_nxt = itgt_sat;
          if (cmd_r) begin
            ospd_nxt = otgt_sat;
            ispd_nxt = itgt_sat;
          end
        end
      end
      ST_SCALE: begin
        outer_nxt = OW'(prod_rnd);
        pass_nxt  = pass_r + PASS_W'(1);
      end
      ST_EASE_O: ospd_nxt = o_up ? ospd_r + SPD_W'(prod_rnd) : ospd_r - SPD_W'(prod_rnd);
      ST_EASE_I: ispd_nxt = i_up ? ispd_r + SPD_W'(prod_rnd) : ispd_r - SPD_W'(prod_rnd);
      ST_ANGLE: begin
        oang_nxt = (oang_sum > DEG360) ? ANG_W'(oang_sum - DEG360) : ANG_W'(oang_sum);
        iang_nxt = (iang_sum > DEG360) ? ANG_W'(iang_sum - DEG360) : ANG_W'(iang_sum);
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.outer_angle    = oang_r;
          out_nxt.inner_angle    = iang_r;
          out_nxt.outer_speed    = ospd_r;
          out_nxt.inner_speed    = ispd_r;
          out_nxt.ratio_now      = ratio_r;
          out_nxt.in_transition  = easing_r;
          out_nxt.rescale_capped = capped_r;
        end
      end
      default: out_nxt = out_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_spd_r <= SPD_W'(19661);
      max_spd_r <= SPD_W'(45875);
      min_rat_r <= SPD_W'(91750);
      max_rat_r <= SPD_W'(104858);
      fix_rat_r <= SPD_W'(106039);
      mode_r    <= MODE_RANDOM;
      stable_r  <= 10'd188;
      oang_r <= '0;  iang_r <= '0;
      ospd_r <= OUTER_RST; ispd_r <= INNER_RST;
      otgt_r <= OUTER_RST; itgt_r <= INNER_RST;
      ratio_r <= RATIO_RST;
      easing_r <= 1'b0; capped_r <= 1'b0;
      sc_r <= '0; ec_r <= '0;
      cidx_t_r <= '0; cidx_c_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_SPEED:    min_spd_r <= cfg_data;
          REG_MAX_SPEED:    max_spd_r <= cfg_data;
          REG_MIN_RATIO:    min_rat_r <= cfg_data;
          REG_MAX_RATIO:    max_rat_r <= cfg_data;
          REG_FIXED_RATIO:  fix_rat_r <= cfg_data;
          REG_RATIO_MODE:   mode_r    <= cfg_data[1:0];
          REG_STABLE_TICKS: stable_r  <= cfg_data[9:0];
          default: ;
        endcase
      end
      oang_r <= oang_nxt;  iang_r <= iang_nxt;
      ospd_r <= ospd_nxt;  ispd_r <= ispd_nxt;
      otgt_r <= otgt_nxt;  itgt_r <= itgt_nxt;
      ratio_r <= ratio_nxt;
      easing_r <= easing_nxt; capped_r <= capped_nxt;
      sc_r <= sc_nxt; ec_r <= ec_nxt;
      cidx_t_r <= cidx_t_nxt; cidx_c_r <= cidx_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    sdraw_r <= sdraw_nxt;
    rdraw_r <= rdraw_nxt;
    outer_r <= outer_nxt;
    inner_r <= inner_nxt;
    pass_r  <= pass_nxt;
    out_r   <= out_nxt;
  end

endmodule
